// ===== rtl/irpd_pkg.sv =====
// Calibration table and segment constants for the IR proximity linearizer.
// Self-contained; used by ir_proximity_to_distance_unit.
`timescale 1ns / 1ps

package irpd_pkg;

	localparam int NUM_SEG     = 8;
	localparam int RECIP_SHIFT = 37;

	typedef logic [2:0]  seg_idx_t;
	typedef logic [11:0] count_t;
	typedef logic [16:0] dist_t;

	localparam count_t TOUCH_LIMIT = 12'd4094;
	localparam count_t FAR_LIMIT   = 12'd34;

	// upper breakpoint (xa) of each segment
	localparam count_t SEG_XA [NUM_SEG] = '{
		12'd4095, 12'd3474, 12'd2211, 12'd676, 12'd306, 12'd164, 12'd90, 12'd56
	};
	// lower breakpoint (xb) of each segment
	localparam count_t SEG_XB [NUM_SEG] = '{
		12'd3474, 12'd2211, 12'd676, 12'd306, 12'd164, 12'd90, 12'd56, 12'd34
	};
	// distance at xa
	localparam dist_t SEG_YA [NUM_SEG] = '{
		17'd0, 17'd5000, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000, 17'd60000
	};
	// distance step across the segment
	localparam logic [13:0] SEG_DY [NUM_SEG] = '{
		14'd5000, 14'd5000, 14'd10000, 14'd10000, 14'd10000, 14'd10000, 14'd10000, 14'd10000
	};
	// xa - xb
	localparam logic [10:0] SEG_DEN [NUM_SEG] = '{
		11'd621, 11'd1263, 11'd1535, 11'd370, 11'd142, 11'd74, 11'd34, 11'd22
	};
	// ceil(2^37 / (2*den)); exact quotient for dividends below 2^25
	localparam logic [31:0] SEG_RECIP [NUM_SEG] = '{
		32'(((64'd1 << RECIP_SHIFT) + 64'd1241) / 64'd1242),
		32'(((64'd1 << RECIP_SHIFT) + 64'd2525) / 64'd2526),
		32'(((64'd1 << RECIP_SHIFT) + 64'd3069) / 64'd3070),
		32'(((64'd1 << RECIP_SHIFT) + 64'd739) / 64'd740),
		32'(((64'd1 << RECIP_SHIFT) + 64'd283) / 64'd284),
		32'(((64'd1 << RECIP_SHIFT) + 64'd147) / 64'd148),
		32'(((64'd1 << RECIP_SHIFT) + 64'd67) / 64'd68),
		32'(((64'd1 << RECIP_SHIFT) + 64'd43) / 64'd44)
	};

endpackage

// ===== rtl/ir_proximity_to_distance_unit.sv =====
// IR proximity linearizer: 12-bit count in, distance in micrometres out.
// Depends on irpd_pkg for the calibration table and reciprocals.
`timescale 1ns / 1ps

// One item is taken on every clock where start is high; busy never rises,
// so the unit sustains one item per cycle. Each result appears on
// distance_um / out_of_range for exactly one cycle, flagged by done, in
// the order the items came in. The receiver cannot stall the pipeline,
// so it must sample on every done. Readings above 4094 give distance 0;
// readings below 34 give distance 0 with out_of_range set. In between,
// the distance is linearly interpolated within the calibration segment
// holding the reading and rounded to the nearest micrometre (halves up).
// Each item passes through five register stages: segment select, delta
// multiply, rounding add, reciprocal multiply, final offset add.
module ir_proximity_to_distance_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] proximity,
	output logic        done,
	output logic [16:0] distance_um,
	output logic        out_of_range
);

	// ---- stage 1: segment select -------------------------------------
	irpd_pkg::seg_idx_t seg_c;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	irpd_pkg::count_t   p_s1;
	irpd_pkg::seg_idx_t seg_s1, seg_s2, seg_s3, seg_s4;
	logic               zero_s1, zero_s2, zero_s3, zero_s4;
	logic               oor_s1, oor_s2, oor_s3, oor_s4, oor_s5;
	logic [23:0]        num_s2;
	logic [24:0]        t_s3;
	logic [13:0]        q_s4;
	irpd_pkg::dist_t    dist_s5;

	logic [11:0]        diff_c;
	logic [25:0]        num_c;
	logic [56:0]        prod_c;

	assign busy = 1'b0;

	// first segment whose lower breakpoint is at or below the reading;
	// scanning down leaves the lowest matching index
	always_comb begin
		seg_c = irpd_pkg::seg_idx_t'(irpd_pkg::NUM_SEG - 1);
		for (int i = irpd_pkg::NUM_SEG - 1; i >= 0; i--) begin
			if (proximity >= irpd_pkg::SEG_XB[i]) begin
				seg_c = irpd_pkg::seg_idx_t'(i);
			end
		end
	end

	// ---- stage 2: (xa - p) * dy --------------------------------------
	assign diff_c = irpd_pkg::SEG_XA[seg_s1] - p_s1;
	assign num_c  = diff_c * irpd_pkg::SEG_DY[seg_s1];

	// ---- stage 4: quotient by reciprocal ------------------------------
	// t = 2*num + den, quotient = floor(t / (2*den)) <= dy
	assign prod_c = t_s3 * irpd_pkg::SEG_RECIP[seg_s3];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		// s1
		p_s1    <= proximity;
		seg_s1  <= seg_c;
		oor_s1  <= proximity < irpd_pkg::FAR_LIMIT;
		zero_s1 <= (proximity < irpd_pkg::FAR_LIMIT) ||
			(proximity > irpd_pkg::TOUCH_LIMIT);
		// s2
		num_s2  <= num_c[23:0];
		seg_s2  <= seg_s1;
		oor_s2  <= oor_s1;
		zero_s2 <= zero_s1;
		// s3: rounding bias
		t_s3    <= {num_s2, 1'b0} + 25'(irpd_pkg::SEG_DEN[seg_s2]);
		seg_s3  <= seg_s2;
		oor_s3  <= oor_s2;
		zero_s3 <= zero_s2;
		// s4
		q_s4    <= prod_c[irpd_pkg::RECIP_SHIFT +: 14];
		seg_s4  <= seg_s3;
		oor_s4  <= oor_s3;
		zero_s4 <= zero_s3;
		// s5: offset, or zero for the touching and too-far cases
		dist_s5 <= zero_s4 ? '0 : irpd_pkg::SEG_YA[seg_s4] + 17'(q_s4);
		oor_s5  <= oor_s4;
	end

	assign done         = vld_s5;
	assign distance_um  = dist_s5;
	assign out_of_range = oor_s5;

endmodule
